// ===== rtl/core/fdcp_pkg.sv =====
package fdcp_pkg;

   // Number format of the parsed value
   localparam int INT_BITS    = 16;
   localparam int FRAC_BITS   = 16;
   localparam int FRAC_DIGITS = 5;
   localparam int VALUE_W     = INT_BITS + FRAC_BITS;

   localparam int CHAR_W     = 8;
   localparam int CMD_W      = 9;
   localparam int CMD_OUT_W  = 8;
   localparam int POS_W      = 3;
   localparam int FRAC_ACC_W = 17;

   localparam logic [CMD_W-1:0] CMD_SAT = '1;
   localparam logic [INT_BITS-1:0] INT_MAX = '1;
   localparam logic [FRAC_BITS-1:0] FRAC_MAX = '1;

   // Character codes
   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;

   // Fraction scaling: 10^k = 2^k * 5^k, the 2^k part is folded into the shift
   localparam int FRAC_SCALE  = 10 ** FRAC_DIGITS;
   localparam int ODD_DIV     = 5 ** FRAC_DIGITS;
   localparam int FRAC_SHIFT  = FRAC_BITS - FRAC_DIGITS;
   localparam int HALF_STEP   = (FRAC_SCALE / 2) >> FRAC_DIGITS;
   localparam int SCALED_W    = 28;
   localparam int RECIP       = (2 ** SCALED_W) / ODD_DIV;
   localparam int RECIP_W     = 17;
   localparam int QUOT_W      = 17;
   localparam int ODD_DIV_W   = 12;

   // CSR map
   localparam int ADDR_W   = 4;
   localparam int CSR_W    = 32;
   localparam logic [1:0] REG_START = 2'd0;
   localparam logic [1:0] REG_STOP  = 2'd1;
   localparam logic [1:0] REG_DELIM = 2'd2;
   localparam logic [1:0] REG_COUNT = 2'd3;

   localparam logic [CHAR_W-1:0] START_RESET = 8'd36;
   localparam logic [CHAR_W-1:0] STOP_RESET  = 8'd35;
   localparam logic [CHAR_W-1:0] DELIM_RESET = 8'd58;
   localparam logic [CMD_W-1:0]  COUNT_RESET = 9'd8;

   typedef struct packed {
      logic                  ok;
      logic [CMD_OUT_W-1:0]  command;
      logic [INT_BITS-1:0]   integer_part;
      logic                  saturated;
   } meta_type;

   typedef struct packed {
      meta_type              meta;
      logic [FRAC_ACC_W-1:0] fraction_acc;
      logic [POS_W-1:0]      fraction_pos;
   } snap_type;

   function automatic logic [FRAC_ACC_W-1:0] pow_ten(input logic [POS_W-1:0] n);
      logic [FRAC_ACC_W-1:0] p;
      case (n)
         3'd0: p = 17'd1;
         3'd1: p = 17'd10;
         3'd2: p = 17'd100;
         3'd3: p = 17'd1000;
         3'd4: p = 17'd10000;
         3'd5: p = 17'd100000;
         default: p = 17'd1;
      endcase
      return p;
   endfunction

endpackage

// ===== rtl/core/fdcp_parser.sv =====
module fdcp_parser
   import fdcp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              req_valid,
   input  logic [CHAR_W-1:0] req_char_in,
   input  logic              req_is_last,
   input  logic [CHAR_W-1:0] start_char,
   input  logic [CHAR_W-1:0] stop_char,
   input  logic [CHAR_W-1:0] delimiter_char,
   input  logic [CMD_W-1:0]  command_count,
   output snap_type          snap,
   output logic              snap_valid
);

   localparam logic [1:0] PH_FIRST   = 2'd0;
   localparam logic [1:0] PH_COMMAND = 2'd1;
   localparam logic [1:0] PH_DATA    = 2'd2;
   localparam logic [1:0] PH_DONE    = 2'd3;

   logic                  in_valid_ff;
   logic [CHAR_W-1:0]     in_char_ff;
   logic                  in_last_ff;

   logic [1:0]            phase_ff, phase_in;
   logic [CMD_W-1:0]      cmd_acc_ff, cmd_acc_in;
   logic [INT_BITS-1:0]   int_acc_ff, int_acc_in;
   logic [FRAC_ACC_W-1:0] frac_acc_ff, frac_acc_in;
   logic [POS_W-1:0]      frac_pos_ff, frac_pos_in;
   logic                  point_ff, point_in;
   logic                  error_ff, error_in;
   logic                  sat_ff, sat_in;

   snap_type              snap_ff, snap_in;
   logic                  snap_valid_ff;

   logic                  digit;
   logic [3:0]            digit_val;
   logic [12:0]           cmd_step;
   logic [INT_BITS+3:0]   int_step;
   logic [FRAC_ACC_W-1:0] frac_step;
   logic                  ok;

   always_comb begin
      digit     = in_char_ff inside {[CHAR_ZERO:CHAR_NINE]};
      digit_val = digit ? in_char_ff[3:0] : 4'd0;
      cmd_step  = 13'(cmd_acc_ff) * 13'd10 + 13'(digit_val);
      int_step  = (INT_BITS+4)'(int_acc_ff) * (INT_BITS+4)'(10) + (INT_BITS+4)'(digit_val);
      frac_step = frac_acc_ff * 17'd10 + 17'(digit_val);

      phase_in    = phase_ff;
      cmd_acc_in  = cmd_acc_ff;
      int_acc_in  = int_acc_ff;
      frac_acc_in = frac_acc_ff;
      frac_pos_in = frac_pos_ff;
      point_in    = point_ff;
      sat_in      = sat_ff;
      error_in    = error_ff || (in_char_ff == CHAR_NUL);

      case (phase_ff)
         PH_FIRST: begin
            if (in_char_ff != start_char) error_in = 1'b1;
            phase_in = (in_char_ff == delimiter_char) ? PH_DATA : PH_COMMAND;
         end
         PH_COMMAND: begin
            if (in_char_ff == delimiter_char) begin
               phase_in = PH_DATA;
            end else if (digit) begin
               cmd_acc_in = (cmd_step > 13'(CMD_SAT)) ? CMD_SAT : cmd_step[CMD_W-1:0];
            end else begin
               error_in = 1'b1;
            end
         end
         PH_DATA: begin
            if (in_char_ff == stop_char) begin
               phase_in = PH_DONE;
            end else if (digit) begin
               if (point_ff) begin
                  if (frac_pos_ff < POS_W'(FRAC_DIGITS)) begin
                     frac_acc_in = frac_step;
                     frac_pos_in = frac_pos_ff + 3'd1;
                  end
               end else if (int_step > (INT_BITS+4)'(INT_MAX)) begin
                  int_acc_in = INT_MAX;
                  sat_in     = 1'b1;
               end else begin
                  int_acc_in = int_step[INT_BITS-1:0];
               end
            end else if (in_char_ff == CHAR_POINT) begin
               point_in = 1'b1;
            end else begin
               error_in = 1'b1;
            end
         end
         default: begin
         end
      endcase

      ok = !error_in && (in_char_ff == stop_char) &&
           ((phase_in == PH_DATA) || (phase_in == PH_DONE)) &&
           (cmd_acc_in < command_count);

      snap_in.meta.ok           = ok;
      snap_in.meta.command      = cmd_acc_in[CMD_OUT_W-1:0];
      snap_in.meta.integer_part = int_acc_in;
      snap_in.meta.saturated    = sat_in;
      snap_in.fraction_acc      = frac_acc_in;
      snap_in.fraction_pos      = frac_pos_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         snap_valid_ff <= 1'b0;
         phase_ff      <= PH_FIRST;
         cmd_acc_ff    <= '0;
         int_acc_ff    <= '0;
         frac_acc_ff   <= '0;
         frac_pos_ff   <= '0;
         point_ff      <= 1'b0;
         error_ff      <= 1'b0;
         sat_ff        <= 1'b0;
      end else if (advance) begin
         in_valid_ff   <= req_valid;
         snap_valid_ff <= in_valid_ff && in_last_ff;
         if (in_valid_ff) begin
            if (in_last_ff) begin
               phase_ff    <= PH_FIRST;
               cmd_acc_ff  <= '0;
               int_acc_ff  <= '0;
               frac_acc_ff <= '0;
               frac_pos_ff <= '0;
               point_ff    <= 1'b0;
               error_ff    <= 1'b0;
               sat_ff      <= 1'b0;
            end else begin
               phase_ff    <= phase_in;
               cmd_acc_ff  <= cmd_acc_in;
               int_acc_ff  <= int_acc_in;
               frac_acc_ff <= frac_acc_in;
               frac_pos_ff <= frac_pos_in;
               point_ff    <= point_in;
               error_ff    <= error_in;
               sat_ff      <= sat_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         in_char_ff <= req_char_in;
         in_last_ff <= req_is_last;
         snap_ff    <= snap_in;
      end
   end

   assign snap       = snap_ff;
   assign snap_valid = snap_valid_ff;

   // a closing byte always leaves the parser back at the frame start
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      advance && in_valid_ff && in_last_ff |=> phase_ff == PH_FIRST && !error_ff)
      else $error("parser not cleared after last word");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      frac_pos_ff <= POS_W'(FRAC_DIGITS))
      else $error("fraction digit count past limit");

endmodule

// ===== rtl/core/fdcp_scaler.sv =====
module fdcp_scaler
   import fdcp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  snap_type             snap,
   input  logic                 snap_valid,
   input  logic                 rsp_ready,
   output logic                 advance,
   output logic                 rsp_valid,
   output logic                 rsp_frame_ok,
   output logic [CMD_OUT_W-1:0] rsp_command,
   output logic [VALUE_W-1:0]   rsp_fixed_value,
   output logic                 rsp_value_saturated
);

   localparam int PROD_W = SCALED_W + RECIP_W;
   localparam int BACK_W = QUOT_W + ODD_DIV_W;

   logic                  s2_valid_ff;
   meta_type              s2_meta_ff;
   logic [FRAC_ACC_W-1:0] s2_frac_ff;

   logic                  s3_valid_ff;
   meta_type              s3_meta_ff;
   logic [SCALED_W-1:0]   s3_scaled_ff;
   logic [QUOT_W-1:0]     s3_quot_ff;

   logic                  rsp_valid_ff;
   logic                  rsp_ok_ff;
   logic [CMD_OUT_W-1:0]  rsp_cmd_ff;
   logic [VALUE_W-1:0]    rsp_value_ff;
   logic                  rsp_sat_ff;

   logic [2*FRAC_ACC_W-1:0] frac_wide;
   logic [SCALED_W-1:0]     scaled;
   logic [PROD_W-1:0]       recip_prod;
   logic [BACK_W-1:0]       back;
   logic [SCALED_W-1:0]     rem;
   logic [QUOT_W-1:0]       quot;
   logic [FRAC_BITS-1:0]    frac_out;

   assign advance = !rsp_valid_ff || rsp_ready;

   always_comb begin
      // bring the decimal fraction up to FRAC_DIGITS digits
      frac_wide  = (2*FRAC_ACC_W)'(snap.fraction_acc) *
                   (2*FRAC_ACC_W)'(pow_ten(POS_W'(FRAC_DIGITS) - snap.fraction_pos));
      // (F * 2^FRAC_BITS + half) / 2^FRAC_DIGITS, exact
      scaled     = {s2_frac_ff, FRAC_SHIFT'(0)} + SCALED_W'(HALF_STEP);
      recip_prod = PROD_W'(scaled) * PROD_W'(RECIP);
      // estimate is low by at most one
      back       = BACK_W'(s3_quot_ff) * BACK_W'(ODD_DIV);
      rem        = s3_scaled_ff - back[SCALED_W-1:0];
      quot       = s3_quot_ff + QUOT_W'(rem >= SCALED_W'(ODD_DIV));
      frac_out   = (quot > QUOT_W'(FRAC_MAX)) ? FRAC_MAX : quot[FRAC_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff  <= snap_valid;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_meta_ff   <= snap.meta;
         s2_frac_ff   <= frac_wide[FRAC_ACC_W-1:0];
         s3_meta_ff   <= s2_meta_ff;
         s3_scaled_ff <= scaled;
         s3_quot_ff   <= recip_prod[SCALED_W +: QUOT_W];
         rsp_ok_ff    <= s3_meta_ff.ok;
         rsp_cmd_ff   <= s3_meta_ff.ok ? s3_meta_ff.command : '0;
         rsp_value_ff <= s3_meta_ff.ok ? {s3_meta_ff.integer_part, frac_out} : '0;
         rsp_sat_ff   <= s3_meta_ff.ok && s3_meta_ff.saturated;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_frame_ok        = rsp_ok_ff;
   assign rsp_command         = rsp_cmd_ff;
   assign rsp_fixed_value     = rsp_value_ff;
   assign rsp_value_saturated = rsp_sat_ff;

   // reciprocal estimate must need at most one correction step
   a_recip_bound: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> rem < SCALED_W'(2 * ODD_DIV))
      else $error("fraction quotient estimate out of range");

   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ok_ff |-> rsp_cmd_ff == '0 && rsp_value_ff == '0 && !rsp_sat_ff)
      else $error("rejected frame carries nonzero fields");

endmodule

// ===== rtl/core/framed_decimal_command_parser.sv =====
// Framed decimal command parser. Takes one message byte per word on the req
// channel (req_is_last marks the closing byte) and returns one word on the rsp
// channel per message: frame_ok, the command number and an unsigned 16.16
// fixed-point value, with value_saturated set if the integer part clamped.
// A frame is start_char, decimal command digits, delimiter_char, decimal
// digits with optional points, then stop_char; bytes after the first stop
// byte only count if they are zero (which rejects the frame). Fraction digits
// past five are dropped and the fraction is rounded to nearest, ties up.
// Rate: one byte per clock, sustained while rsp words are taken. Each message
// result passes the pipeline input register, the frame snapshot, two
// fraction scaling stages (table multiply, then reciprocal multiply) and
// the result register. All stages share one enable, so a held rsp word
// stalls the whole pipe, and req_ready drops with it.
// CSRs (APB, 32-bit, byte addresses): 0x0 start_char, 0x4 stop_char,
// 0x8 delimiter_char, 0xC command_count (9 bits). Write them only while idle.
module framed_decimal_command_parser
   import fdcp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,

   // input bytes
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [CHAR_W-1:0]    req_char_in,
   input  logic                 req_is_last,

   // parse results
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_frame_ok,
   output logic [CMD_OUT_W-1:0] rsp_command,
   output logic [VALUE_W-1:0]   rsp_fixed_value,
   output logic                 rsp_value_saturated,

   // CSR port
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_W-1:0]    paddr,
   input  logic [CSR_W-1:0]     pwdata,
   output logic [CSR_W-1:0]     prdata,
   output logic                 pready
);

   logic [CHAR_W-1:0] start_ff;
   logic [CHAR_W-1:0] stop_ff;
   logic [CHAR_W-1:0] delim_ff;
   logic [CMD_W-1:0]  count_ff;

   logic       csr_write;
   logic [1:0] csr_index;
   logic       advance;
   snap_type   snap;
   logic       snap_valid;

   // zero-wait APB: write lands on the access phase
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= START_RESET;
         stop_ff  <= STOP_RESET;
         delim_ff <= DELIM_RESET;
         count_ff <= COUNT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_START: start_ff <= pwdata[CHAR_W-1:0];
            REG_STOP:  stop_ff  <= pwdata[CHAR_W-1:0];
            REG_DELIM: delim_ff <= pwdata[CHAR_W-1:0];
            REG_COUNT: count_ff <= pwdata[CMD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_START: prdata = CSR_W'(start_ff);
         REG_STOP:  prdata = CSR_W'(stop_ff);
         REG_DELIM: prdata = CSR_W'(delim_ff);
         REG_COUNT: prdata = CSR_W'(count_ff);
         default:   prdata = '0;
      endcase
   end

   // whole pipe moves together; input is taken whenever the pipe moves
   assign req_ready = advance;

   fdcp_parser u_parser (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .req_valid      (req_valid),
      .req_char_in    (req_char_in),
      .req_is_last    (req_is_last),
      .start_char     (start_ff),
      .stop_char      (stop_ff),
      .delimiter_char (delim_ff),
      .command_count  (count_ff),
      .snap           (snap),
      .snap_valid     (snap_valid)
   );

   // fraction scaling and result register
   fdcp_scaler u_scaler (
      .clock               (clock),
      .reset               (reset),
      .snap                (snap),
      .snap_valid          (snap_valid),
      .rsp_ready           (rsp_ready),
      .advance             (advance),
      .rsp_valid           (rsp_valid),
      .rsp_frame_ok        (rsp_frame_ok),
      .rsp_command         (rsp_command),
      .rsp_fixed_value     (rsp_fixed_value),
      .rsp_value_saturated (rsp_value_saturated)
   );

   // a finished frame can only report a command below the configured count
   a_cmd_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_ok |-> CMD_W'(rsp_command) < count_ff)
      else $error("accepted frame with command out of range");

endmodule

// ===== bench/parse_result_checker.sv =====
`timescale 1ns / 100ps

// Watches the byte, result and CSR ports of the frame parser, predicts the
// result word of every message and compares it with what comes out.
module parse_result_checker
   import fdcp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic [CHAR_W-1:0]    req_char_in,
   input  logic                 req_is_last,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic                 rsp_frame_ok,
   input  logic [CMD_OUT_W-1:0] rsp_command,
   input  logic [VALUE_W-1:0]   rsp_fixed_value,
   input  logic                 rsp_value_saturated,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_W-1:0]    paddr,
   input  logic [CSR_W-1:0]     pwdata,
   input  logic                 pready,
   output int                   outstanding,
   output int                   mismatch_count
);

   typedef enum logic [1:0] {AWAIT_START, IN_COMMAND, IN_DATA, PAST_STOP} parse_stage_type;

   typedef struct {
      logic                 ok;
      logic [CMD_OUT_W-1:0] command;
      logic [VALUE_W-1:0]   value;
      logic                 saturated;
   } frame_result_type;

   frame_result_type expected_frames[$];
   frame_result_type want;

   // register copies
   logic [CHAR_W-1:0] start_char, stop_char, delim_char;
   logic [CMD_W-1:0]  cmd_count;

   // parse state
   parse_stage_type stage;
   int unsigned     cmd_sum;
   longint unsigned int_sum, frac_sum;
   int              frac_digits;
   logic            point_flag, bad_flag, clamp_flag;

   // per-byte scratch
   logic [CHAR_W-1:0] ch;
   logic              is_digit, ok;
   int unsigned       digit;
   longint unsigned   wide, scaled, frac_bin, value64;
   int                k;

   always @(posedge clock) begin
      if (reset) begin
         start_char = START_RESET;
         stop_char  = STOP_RESET;
         delim_char = DELIM_RESET;
         cmd_count  = COUNT_RESET;
         stage = AWAIT_START;
         cmd_sum = 0; int_sum = 0; frac_sum = 0; frac_digits = 0;
         point_flag = 0; bad_flag = 0; clamp_flag = 0;
         mismatch_count = 0;
         expected_frames.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[ADDR_W-1:2])
               REG_START: start_char = pwdata[CHAR_W-1:0];
               REG_STOP:  stop_char  = pwdata[CHAR_W-1:0];
               REG_DELIM: delim_char = pwdata[CHAR_W-1:0];
               REG_COUNT: cmd_count  = pwdata[CMD_W-1:0];
               default: ;
            endcase
         end

         if (req_valid && req_ready) begin
            ch       = req_char_in;
            is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
            digit    = is_digit ? int'(ch - CHAR_ZERO) : 0;
            if (ch == CHAR_NUL) bad_flag = 1;
            case (stage)
               AWAIT_START: begin
                  if (ch != start_char) bad_flag = 1;
                  stage = (ch == delim_char) ? IN_DATA : IN_COMMAND;
               end
               IN_COMMAND: begin
                  if (ch == delim_char) begin
                     stage = IN_DATA;
                  end else if (is_digit) begin
                     wide    = cmd_sum * 10 + digit;
                     cmd_sum = (wide > CMD_SAT) ? CMD_SAT : int'(wide);
                  end else begin
                     bad_flag = 1;
                  end
               end
               IN_DATA: begin
                  if (ch == stop_char) begin
                     stage = PAST_STOP;
                  end else if (is_digit) begin
                     if (point_flag) begin
                        if (frac_digits < FRAC_DIGITS) begin
                           frac_sum = frac_sum * 10 + digit;
                           frac_digits++;
                        end
                     end else begin
                        wide = int_sum * 10 + digit;
                        if (wide > INT_MAX) begin
                           wide       = INT_MAX;
                           clamp_flag = 1;
                        end
                        int_sum = wide;
                     end
                  end else if (ch == CHAR_POINT) begin
                     point_flag = 1;
                  end else begin
                     bad_flag = 1;
                  end
               end
               default: ;
            endcase

            if (req_is_last) begin
               ok = !bad_flag && (ch == stop_char) &&
                    (stage == IN_DATA || stage == PAST_STOP) && (cmd_sum < cmd_count);
               // decimal fraction to binary, round half up
               scaled = frac_sum;
               for (k = frac_digits; k < FRAC_DIGITS; k++) scaled = scaled * 10;
               frac_bin = ((scaled << FRAC_BITS) + FRAC_SCALE / 2) / FRAC_SCALE;
               if (frac_bin > FRAC_MAX) frac_bin = FRAC_MAX;
               value64 = (int_sum << FRAC_BITS) | frac_bin;
               want.ok        = ok;
               want.command   = ok ? cmd_sum[CMD_OUT_W-1:0] : '0;
               want.value     = ok ? value64[VALUE_W-1:0] : '0;
               want.saturated = ok && clamp_flag;
               expected_frames.push_back(want);
               stage = AWAIT_START;
               cmd_sum = 0; int_sum = 0; frac_sum = 0; frac_digits = 0;
               point_flag = 0; bad_flag = 0; clamp_flag = 0;
            end
         end

         if (rsp_valid && rsp_ready) begin
            if (expected_frames.size() == 0) begin
               $display("%0t: result word with none pending, frame_ok %0d command %0d value %h",
                        $time, rsp_frame_ok, rsp_command, rsp_fixed_value);
               mismatch_count++;
            end else begin
               want = expected_frames.pop_front();
               if (rsp_frame_ok !== want.ok) begin
                  $display("%0t: frame_ok expected %0d actual %0d",
                           $time, want.ok, rsp_frame_ok);
                  mismatch_count++;
               end
               if (rsp_command !== want.command) begin
                  $display("%0t: command expected %0d actual %0d",
                           $time, want.command, rsp_command);
                  mismatch_count++;
               end
               if (rsp_fixed_value !== want.value) begin
                  $display("%0t: fixed_value expected %h actual %h",
                           $time, want.value, rsp_fixed_value);
                  mismatch_count++;
               end
               if (rsp_value_saturated !== want.saturated) begin
                  $display("%0t: value_saturated expected %0d actual %0d",
                           $time, want.saturated, rsp_value_saturated);
                  mismatch_count++;
               end
            end
         end
      end
      // registered copy for the stimulus, taken after this edge's push and pop
      outstanding <= expected_frames.size();
   end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

// Top of the parser bench: clock, reset, byte stimulus, CSR writes and the
// result-side stall pattern. All checking lives in parse_result_checker.
module tb;
   import fdcp_pkg::*;

   typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_QUARTER, RX_SIXTEENTH} rx_mode_type;

   logic                 clock;
   logic                 reset = 1'b1;

   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [CHAR_W-1:0]    req_char_in = '0;
   logic                 req_is_last = 1'b0;

   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_frame_ok;
   logic [CMD_OUT_W-1:0] rsp_command;
   logic [VALUE_W-1:0]   rsp_fixed_value;
   logic                 rsp_value_saturated;

   logic                 psel = 1'b0;
   logic                 penable = 1'b0;
   logic                 pwrite = 1'b0;
   logic [ADDR_W-1:0]    paddr = '0;
   logic [CSR_W-1:0]     pwdata = '0;
   logic [CSR_W-1:0]     prdata;
   logic                 pready;

   int outstanding;
   int mismatch_count;

   // what the generator believes the parser is set to
   logic [CHAR_W-1:0] cfg_start = START_RESET;
   logic [CHAR_W-1:0] cfg_stop  = STOP_RESET;
   logic [CHAR_W-1:0] cfg_delim = DELIM_RESET;
   logic [CMD_W-1:0]  cfg_count = COUNT_RESET;

   logic [CHAR_W-1:0] msg[$];   // bytes of the message being built
   int burst_left = 0;          // words left in the current sender burst

   // receiver stall state
   rx_mode_type rx_mode = RX_OPEN;
   int          rx_mode_left = 0;
   logic [7:0]  rx_tick = '0;

   framed_decimal_command_parser DUT (
      .clock, .reset,
      .req_valid, .req_ready, .req_char_in, .req_is_last,
      .rsp_valid, .rsp_ready, .rsp_frame_ok, .rsp_command, .rsp_fixed_value,
      .rsp_value_saturated,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   parse_result_checker u_checker (
      .clock, .reset,
      .req_valid, .req_ready, .req_char_in, .req_is_last,
      .rsp_valid, .rsp_ready, .rsp_frame_ok, .rsp_command, .rsp_fixed_value,
      .rsp_value_saturated,
      .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
      .outstanding, .mismatch_count
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard stop in case the pipe locks up or a result never shows.
   initial begin
      #5_000_000;
      $display("[framed_decimal_command_parser] ERROR");
      $finish;
   end

   // Result side: a stall mode is held for a random stretch, then redrawn.
   // Open mode gives runs with no backpressure at all; the sixteenth mode
   // raises ready least often, and a held word stalls the whole pipe.
   always @(posedge clock) begin
      if (rx_mode_left == 0) begin
         rx_mode      <= rx_mode_type'($urandom_range(0, 3));
         rx_mode_left <= $urandom_range(20, 200);
      end else begin
         rx_mode_left <= rx_mode_left - 1;
      end
      rx_tick <= rx_tick + 1;
      case (rx_mode)
         RX_OPEN:      rsp_ready <= 1'b1;
         RX_COIN:      rsp_ready <= 1'($urandom_range(0, 1));
         RX_QUARTER:   rsp_ready <= (rx_tick[1:0] == 2'd0);
         RX_SIXTEENTH: rsp_ready <= (rx_tick[3:0] == 4'd0);
         default:      rsp_ready <= 1'b1;
      endcase
   end

   // One byte word. The sender runs in bursts; between bursts valid drops
   // for a random gap (often zero, so back-to-back runs happen too). Valid
   // stays up across accepted words inside a burst.
   task send_byte(input logic [CHAR_W-1:0] value, input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_valid   <= 1'b1;
      req_char_in <= value;
      req_is_last <= last;
      do @(posedge clock); while (!req_ready);
      burst_left--;
   endtask

   // Sends the built message, marking its final byte, and empties the buffer.
   task send_frame();
      for (int i = 0; i < msg.size(); i++) send_byte(msg[i], i == msg.size() - 1);
      msg.delete();
   endtask

   task queue_text(input string text);
      for (int i = 0; i < text.len(); i++) msg.push_back(text[i]);
   endtask

   // Sender goes quiet until every predicted result word has come out.
   // The first look waits for a clock edge, so a push at this edge is seen.
   task wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // APB write: setup cycle, access cycle, then an idle cycle so that the
   // next write never touches psel twice in one time step.
   task csr_write(input logic [1:0] index, input logic [CSR_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task apply_config(input logic [CHAR_W-1:0] start_c, input logic [CHAR_W-1:0] stop_c,
                     input logic [CHAR_W-1:0] delim_c, input logic [CMD_W-1:0] count);
      cfg_start = start_c;
      cfg_stop  = stop_c;
      cfg_delim = delim_c;
      cfg_count = count;
      csr_write(REG_START, CSR_W'(start_c));
      csr_write(REG_STOP,  CSR_W'(stop_c));
      csr_write(REG_DELIM, CSR_W'(delim_c));
      csr_write(REG_COUNT, CSR_W'(count));
   endtask

   // Frame characters: half the time a plain random byte, else one of the
   // bytes that collide with the syntax (digits, point, defaults, extremes).
   function automatic logic [CHAR_W-1:0] pick_char();
      logic [CHAR_W-1:0] notable[8];
      notable = '{START_RESET, STOP_RESET, DELIM_RESET, CHAR_POINT,
                  CHAR_ZERO, CHAR_NINE, 8'h01, 8'hFF};
      if ($urandom_range(0, 1) == 0) return CHAR_W'($urandom_range(1, 255));
      return notable[$urandom_range(0, 7)];
   endfunction

   // Builds one random message into msg. Mostly a well-formed frame with
   // random command and value, then a share of corrupted frames and noise.
   task compose_message();
      int kind, len, pick, ndig;
      int unsigned cmd, whole;
      logic [CHAR_W-1:0] junk;
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
         // noise: random bytes, sometimes opened like a frame
         len = $urandom_range(1, 6);
         for (int i = 0; i < len; i++) msg.push_back(CHAR_W'($urandom_range(0, 255)));
         if ($urandom_range(0, 3) == 0) msg[0] = cfg_start;
      end else begin
         msg.push_back(cfg_start);
         // command digits; empty now and then, sometimes out of range
         if ($urandom_range(0, 9) != 0) begin
            if ($urandom_range(0, 4) == 0) cmd = $urandom_range(0, 999);
            else cmd = $urandom_range(0, cfg_count - 1);
            if ($urandom_range(0, 7) == 0) msg.push_back(CHAR_ZERO);
            queue_text($sformatf("%0d", cmd));
         end
         msg.push_back(cfg_delim);
         // integer part: none, small, full range, or past 16 bits
         pick = $urandom_range(0, 3);
         if (pick != 0) begin
            case (pick)
               1:       whole = $urandom_range(0, 999);
               2:       whole = $urandom_range(0, 65535);
               default: whole = $urandom_range(65536, 9999999);
            endcase
            queue_text($sformatf("%0d", whole));
         end
         // fraction, up to eight digits, with the odd repeated point
         if ($urandom_range(0, 9) < 7) begin
            msg.push_back(CHAR_POINT);
            ndig = $urandom_range(0, 8);
            for (int i = 0; i < ndig; i++) begin
               if ($urandom_range(0, 9) == 0) msg.push_back(CHAR_POINT);
               msg.push_back(CHAR_ZERO + CHAR_W'($urandom_range(0, 9)));
            end
         end
         msg.push_back(cfg_stop);
         // bytes after the stop byte, closed by another stop byte
         if ($urandom_range(0, 9) == 0) begin
            len = $urandom_range(1, 3);
            for (int i = 0; i < len; i++) begin
               junk = ($urandom_range(0, 7) == 0) ? CHAR_NUL : CHAR_W'($urandom_range(1, 255));
               msg.push_back(junk);
            end
            msg.push_back(cfg_stop);
         end
         // corruption: a random byte, a lost stop byte, or a zero byte
         pick = $urandom_range(0, 19);
         if (pick == 0) msg[$urandom_range(0, msg.size() - 1)] = CHAR_W'($urandom_range(0, 255));
         else if (pick == 1 && msg.size() > 1) void'(msg.pop_back());
         else if (pick == 2) msg[$urandom_range(0, msg.size() - 1)] = CHAR_NUL;
      end
   endtask

   initial begin : stimulus
      int phase_bytes;
      int pick;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed, reset settings: saturating value with max valid command and
      // surplus fraction digits; empty command with repeated points; a lone
      // stop byte (first and last at once); a zero byte closing the message.
      queue_text("$7:70000.999999#");
      send_frame();
      queue_text("$:..5#");
      send_frame();
      queue_text("#");
      send_frame();
      msg.push_back(START_RESET);
      msg.push_back(CHAR_NUL);
      send_frame();

      // Seven settings, ~140 bytes each. Settings only change once the
      // parser has drained, which also gives the full-drain pause.
      for (int phase = 0; phase < 7; phase++) begin
         if (phase > 0) begin
            wait_drained();
            case (phase)
               1: apply_config(8'h01, 8'hFF, CHAR_POINT, 9'd1);
               // start equal to delimiter: command is empty from the first byte
               2: apply_config(8'hFF, 8'h01, 8'hFF, 9'd256);
               default: begin
                  pick = $urandom_range(0, 2);
                  apply_config(pick_char(), pick_char(), pick_char(),
                               (pick == 0) ? 9'd1 : (pick == 1) ? 9'd256
                                           : CMD_W'($urandom_range(1, 256)));
               end
            endcase
         end
         phase_bytes = 0;
         while (phase_bytes < 140) begin
            compose_message();
            phase_bytes += msg.size();
            send_frame();
            if ($urandom_range(0, 24) == 0) wait_drained();
         end
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      // leave room for a stray extra word
      repeat (12) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("[framed_decimal_command_parser] OK");
      end else begin
         $display("[framed_decimal_command_parser] ERROR");
      end
      $finish;
   end

endmodule

// ===== framed_decimal_command_parser.f =====
rtl/core/fdcp_pkg.sv
rtl/core/fdcp_parser.sv
rtl/core/fdcp_scaler.sv
rtl/core/framed_decimal_command_parser.sv
bench/parse_result_checker.sv
bench/tb.sv
